FILE: hw/rtl/sks_pkg.sv
// Shared types and constants for the sorted key set.
package sks_pkg;

   localparam int KEY_W        = 32;
   localparam int FUNC_W       = 2;
   localparam int COUNT_W      = 5;
   localparam int CAPACITY_DEF = 16;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TEST   = 2'd2;

   // What the token moving down the row is doing at the cell it reaches.
   typedef enum logic [2:0] {
      MODE_INSERT,
      MODE_FULL,
      MODE_SHIFT,
      MODE_REMOVE,
      MODE_PULL,
      MODE_TEST,
      MODE_DONE
   } mode_type;

   typedef struct packed {
      logic             valid;
      mode_type         mode;
      logic [KEY_W-1:0] key;
      logic             ok;
      logic             full;
   } token_type;

   typedef struct packed {
      logic               ok;
      logic               full;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

FILE: hw/rtl/sks_cell.sv
// One slot of the sorted row: holds a key and acts on the token passing through.
module sks_cell import sks_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int INDEX    = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  token_type                          tok_in,
   input  logic [KEY_W-1:0]                   nb_key,
   input  logic [$clog2(CAPACITY+1)-1:0]      occ,
   output logic [KEY_W-1:0]                   key_out,
   output token_type                          tok_out
);

   localparam int OCC_W = $clog2(CAPACITY+1);
   localparam logic [OCC_W-1:0] IDX      = OCC_W'(INDEX);
   localparam logic [OCC_W-1:0] NEXT_IDX = OCC_W'(INDEX + 1);

   logic [KEY_W-1:0] key_ff, key_in;
   token_type        tok_ff, tok_in_nx;
   logic             used, last_used, lt, eq;

   assign used      = IDX < occ;
   assign last_used = NEXT_IDX >= occ;
   assign lt        = used && ($signed(key_ff) < $signed(tok_in.key));
   assign eq        = used && (key_ff == tok_in.key);

   always_comb begin
      key_in    = key_ff;
      tok_in_nx = tok_in;
      if (tok_in.valid) begin
         case (tok_in.mode)
            MODE_INSERT: begin
               if (eq) begin
                  tok_in_nx.mode = MODE_DONE;
               end else if (!lt) begin
                  // take the new key, push the displaced one rightward
                  key_in = tok_in.key;
                  if (used) begin
                     tok_in_nx.mode = MODE_SHIFT;
                     tok_in_nx.key  = key_ff;
                  end else begin
                     tok_in_nx.mode = MODE_DONE;
                     tok_in_nx.ok   = 1'b1;
                  end
               end
            end
            MODE_SHIFT: begin
               key_in = tok_in.key;
               if (used) begin
                  tok_in_nx.key = key_ff;
               end else begin
                  tok_in_nx.mode = MODE_DONE;
                  tok_in_nx.ok   = 1'b1;
               end
            end
            MODE_REMOVE: begin
               if (eq) begin
                  key_in = nb_key;
                  tok_in_nx.ok = 1'b1;
                  tok_in_nx.mode = last_used ? MODE_DONE : MODE_PULL;
               end else if (!lt) begin
                  tok_in_nx.mode = MODE_DONE;
               end
            end
            MODE_PULL: begin
               // close the gap: copy from the right neighbor
               key_in = nb_key;
               if (last_used) begin
                  tok_in_nx.mode = MODE_DONE;
               end
            end
            MODE_TEST: begin
               if (eq) begin
                  tok_in_nx.mode = MODE_DONE;
                  tok_in_nx.ok   = 1'b1;
               end else if (!lt) begin
                  tok_in_nx.mode = MODE_DONE;
               end
            end
            MODE_FULL: begin
               if (eq) begin
                  tok_in_nx.mode = MODE_DONE;
               end else if (!lt) begin
                  tok_in_nx.mode = MODE_DONE;
                  tok_in_nx.full = 1'b1;
               end
            end
            MODE_DONE: begin
               tok_in_nx = tok_in;
            end
            default: begin
               tok_in_nx = tok_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nx;
      end
   end

   assign key_out = key_ff;
   assign tok_out = tok_ff;

endmodule

FILE: hw/rtl/sks_rsp_buf.sv
// Two-entry result buffer: output register plus a skid slot.
module sks_rsp_buf import sks_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       out_ready,
   output logic       out_valid,
   output result_type out_data,
   output logic       room
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && !pop) begin
         // hold the output word, park a new one in the skid slot
         if (push) begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = push;
         skid_data_in  = push_data;
      end else begin
         out_valid_in = push;
         out_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign room      = !skid_valid_ff;

endmodule

FILE: hw/rtl/sorted_key_set.sv
// Sorted key set: ascending row of signed keys with insert, remove and test.
//
// Input channel req_*: one word per operation. req_tuser carries the
// operation (insert, remove, membership test), req_tdata the signed key.
// Result channel rsp_*: one word per operation with ok, table_full and the
// number of keys held afterwards.
// Keys sit in a row of CAPACITY cells in ascending order. An operation
// enters the row as a token and moves one cell per cycle, comparing,
// shifting keys right (insert) or pulling them left (remove) on its way.
// An operation passes through every cell of the row, then the result buffer,
// before rsp_tvalid; one operation is in the row at a time, so a new one
// is accepted only after the last has left the row.
// Reset empties the set at once; no sweep is needed.
// A result waits in an output register with one skid slot behind it, so a
// new operation is accepted while a result waits; req_tready stays low
// while an operation is in the row or the skid slot is occupied.
module sorted_key_set import sks_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [KEY_W-1:0]  req_tdata,   // [31:0] key
   input  logic [FUNC_W-1:0] req_tuser,   // [1:0] func
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata    // [0] ok, [1] table_full, [6:2] entry_count
);

   localparam int OCC_W = $clog2(CAPACITY+1);

   logic              busy_ff, busy_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [FUNC_W-1:0] func_ff;
   logic              accept, room;
   token_type         tok_head;
   token_type         tok_chain [CAPACITY+1];
   logic [KEY_W-1:0]  key_row [CAPACITY];
   token_type         exit_tok;
   result_type        result, rsp_data;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy_ff && room;

   always_comb begin
      tok_head.valid = accept;
      tok_head.key   = req_tdata;
      tok_head.ok    = 1'b0;
      tok_head.full  = 1'b0;
      case (req_tuser)
         FUNC_INSERT: begin
            tok_head.mode = (occ_ff == OCC_W'(CAPACITY)) ? MODE_FULL : MODE_INSERT;
         end
         FUNC_REMOVE: tok_head.mode = MODE_REMOVE;
         FUNC_TEST:   tok_head.mode = MODE_TEST;
         default:     tok_head.mode = MODE_DONE;
      endcase
   end

   assign tok_chain[0] = tok_head;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_W-1:0] nb_key;
      if (i == CAPACITY - 1) begin : g_last
         assign nb_key = key_row[i];
      end else begin : g_mid
         assign nb_key = key_row[i+1];
      end
      sks_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok_chain[i]),
         .nb_key  (nb_key),
         .occ     (occ_ff),
         .key_out (key_row[i]),
         .tok_out (tok_chain[i+1])
      );
   end

   assign exit_tok = tok_chain[CAPACITY];

   always_comb begin
      occ_in = occ_ff;
      if (exit_tok.valid && exit_tok.ok) begin
         if (func_ff == FUNC_INSERT) begin
            occ_in = occ_ff + OCC_W'(1);
         end else if (func_ff == FUNC_REMOVE) begin
            occ_in = occ_ff - OCC_W'(1);
         end
      end
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (exit_tok.valid) begin
         busy_in = 1'b0;
      end
      result.ok    = exit_tok.ok;
      // a full-table insert that ran past every key was refused
      result.full  = exit_tok.full || (exit_tok.mode == MODE_FULL);
      result.count = COUNT_W'(occ_in);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_tuser;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         occ_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         occ_ff  <= occ_in;
      end
   end

   sks_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (exit_tok.valid),
      .push_data (result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data),
      .room      (room)
   );

   assign rsp_tdata = {1'b0, rsp_data.count, rsp_data.full, rsp_data.ok};

endmodule

FILE: hw/rtl/sks_checker.sv
// Port-level checks for the sorted key set, bound to the top level.
module sks_checker import sks_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [7:0]        rsp_tdata
);

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_ok_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("ok and table_full both set");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[6:2] == CAP_COUNT)
      else $error("table_full with the table not full");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 31) || (rsp_tdata[6:2] <= CAP_COUNT))
      else $error("entry_count above capacity");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second operation taken while one is in the row");

endmodule

bind sorted_key_set sks_checker #(.CAPACITY(CAPACITY)) u_sks_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
